// ----- hw/rtl/afs_pkg.sv -----
// ----------------------------------------------------------------------------
// afs_pkg - shared types and constants
// Field widths, register indexes, defaults and sequencer states of the
// keyframe sequencer.
// ----------------------------------------------------------------------------
package afs_pkg;

   localparam int MAX_FRAMES_DEFAULT = 64;
   localparam int TIME_BITS_DEFAULT  = 24;

   localparam int COMMAND_W = 1;
   localparam int DELTA_W   = 24;
   localparam int SLOT_W    = 6;
   localparam int ENTRY_W   = 24;
   localparam int FRAME_W   = 6;

   localparam int COUNT_W   = 7;
   localparam int LIMIT_W   = 9;
   localparam int REPS_W    = 8;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;

   localparam logic [CSR_IDX_W-1:0] REG_FRAME_COUNT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_REPEAT_ENABLE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_REPEAT_LIMIT  = 2'd2;

   localparam logic [COMMAND_W-1:0] CMD_TICK = 1'b0;
   localparam logic [COMMAND_W-1:0] CMD_LOAD = 1'b1;

   localparam logic [COUNT_W-1:0] FRAME_COUNT_RESET = 7'd1;
   localparam logic [LIMIT_W-1:0] LIMIT_FOREVER     = 9'h1FF;
   localparam logic [REPS_W-1:0]  REPS_MAX          = 8'hFF;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_READ,
      ST_COMPARE,
      ST_END,
      ST_EMIT
   } state_type;

endpackage

// ----- hw/rtl/afs_req_if.sv -----
// ----------------------------------------------------------------------------
// afs_req_if - request channel
// Tick and load items with valid/ready handshake.
// ----------------------------------------------------------------------------
interface afs_req_if;
   logic                            valid;
   logic                            ready;
   logic [afs_pkg::COMMAND_W-1:0]   command;
   logic [afs_pkg::DELTA_W-1:0]     time_delta;
   logic [afs_pkg::SLOT_W-1:0]      entry_index;
   logic [afs_pkg::ENTRY_W-1:0]     entry_time;

   modport source (output valid, command, time_delta, entry_index, entry_time,
                   input ready);
   modport sink   (input valid, command, time_delta, entry_index, entry_time,
                   output ready);
endinterface

// ----- hw/rtl/afs_rsp_if.sv -----
// ----------------------------------------------------------------------------
// afs_rsp_if - response channel
// Sequencer status and frame pair with valid/ready handshake.
// ----------------------------------------------------------------------------
interface afs_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          active;
   logic [afs_pkg::FRAME_W-1:0]   frame_cur;
   logic [afs_pkg::FRAME_W-1:0]   frame_next;

   modport source (output valid, active, frame_cur, frame_next, input ready);
   modport sink   (input valid, active, frame_cur, frame_next, output ready);
endinterface

// ----- hw/rtl/afs_csr_if.sv -----
// ----------------------------------------------------------------------------
// afs_csr_if - register write channel
// Register index and write data with valid/ready handshake.
// ----------------------------------------------------------------------------
interface afs_csr_if;
   logic                             valid;
   logic                             ready;
   logic [afs_pkg::CSR_IDX_W-1:0]    index;
   logic [afs_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/afs_table.sv -----
// ----------------------------------------------------------------------------
// afs_table - frame end time memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module afs_table #(
   parameter int DEPTH = afs_pkg::MAX_FRAMES_DEFAULT,
   parameter int WIDTH = afs_pkg::TIME_BITS_DEFAULT,
   localparam int IDX_W = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/animation_frame_sequencer.sv -----
// ----------------------------------------------------------------------------
// animation_frame_sequencer - keyframe sequencer
// Load items fill a table of cumulative frame end times. Tick items advance
// a saturating running time and walk the frame index through the table.
//
// Channels: req carries load and tick items, rsp returns one result per item,
// csr writes frame_count, repeat_enable and repeat_limit, which the user must
// write only while idle; nothing in the block checks it. A load goes
// straight to the emit step, a tick on a finished sequence only through the
// check step; other ticks walk until an entry stops them or the last frame;
// the walk reads one entry at a time through the single table read port and
// one shared time comparator. One item is in work at a time; req ready is
// high only while the sequencer is idle, re-entered as the result is loaded.
// The result sits in an output register: when the receiver stalls, the
// sequencer finishes the next item and holds in its last step until the
// register frees up.
// Reset clears the running time, frame index, repetition count and csr
// values. The table has no reset; the user must read entries only once loaded.
// ----------------------------------------------------------------------------
module animation_frame_sequencer #(
   parameter int MAX_FRAMES = afs_pkg::MAX_FRAMES_DEFAULT,
   parameter int TIME_BITS  = afs_pkg::TIME_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   afs_req_if.sink     req_if,
   afs_rsp_if.source   rsp_if,
   afs_csr_if.sink     csr_if
);

   localparam int IDX_W = $clog2(MAX_FRAMES);
   localparam int FI_W  = $clog2(MAX_FRAMES + 1);

   afs_pkg::state_type state_ff, state_in;

   logic [afs_pkg::COUNT_W-1:0] frame_count_ff;
   logic                        repeat_enable_ff;
   logic [afs_pkg::LIMIT_W-1:0] repeat_limit_ff;

   logic [TIME_BITS-1:0]       run_time_ff, run_time_in;
   logic [FI_W-1:0]            frame_index_ff, frame_index_in;
   logic [afs_pkg::REPS_W-1:0] reps_ff, reps_in;

   logic                        res_active_ff, res_active_in;
   logic [afs_pkg::FRAME_W-1:0] res_one_ff, res_one_in;
   logic [afs_pkg::FRAME_W-1:0] res_two_ff, res_two_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_active_ff;
   logic [afs_pkg::FRAME_W-1:0] rsp_one_ff;
   logic [afs_pkg::FRAME_W-1:0] rsp_two_ff;

   logic                 req_xfer;
   logic                 rsp_free;
   logic [FI_W-1:0]      count;
   logic                 seq_done;
   logic                 walk_more;
   logic                 time_past;
   logic [TIME_BITS:0]   time_sum;
   logic [TIME_BITS-1:0] delta_t;
   logic [FI_W:0]        next_frame;

   logic                 tbl_wr_en;
   logic [IDX_W-1:0]     tbl_wr_addr;
   logic [TIME_BITS-1:0] tbl_wr_data;
   logic                 tbl_rd_en;
   logic [TIME_BITS-1:0] tbl_rd_data;

   afs_table #(
      .DEPTH (MAX_FRAMES),
      .WIDTH (TIME_BITS)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_addr),
      .wr_data (tbl_wr_data),
      .rd_en   (tbl_rd_en),
      .rd_addr (frame_index_ff[IDX_W-1:0]),
      .rd_data (tbl_rd_data)
   );

   assign req_if.ready = (state_ff == afs_pkg::ST_IDLE);
   assign req_xfer     = req_if.valid && req_if.ready;
   assign rsp_free     = !rsp_valid_ff || rsp_if.ready;
   assign csr_if.ready = 1'b1;

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.active     = rsp_active_ff;
   assign rsp_if.frame_cur  = rsp_one_ff;
   assign rsp_if.frame_next = rsp_two_ff;

   always_comb begin
      if (frame_count_ff == '0) begin
         count = FI_W'(1);
      end else if (32'(frame_count_ff) > MAX_FRAMES) begin
         count = FI_W'(MAX_FRAMES);
      end else begin
         count = FI_W'(frame_count_ff);
      end
   end

   assign seq_done = (repeat_limit_ff != afs_pkg::LIMIT_FOREVER) &&
                     ($signed({2'b00, reps_ff}) >
                      $signed({repeat_limit_ff[afs_pkg::LIMIT_W-1], repeat_limit_ff}));

   assign walk_more  = frame_index_ff < count;
   assign time_past  = run_time_ff > tbl_rd_data;
   assign delta_t    = TIME_BITS'(32'(req_if.time_delta));
   assign time_sum   = {1'b0, run_time_ff} + {1'b0, delta_t};
   assign next_frame = {1'b0, frame_index_ff} + (FI_W + 1)'(1);

   assign tbl_wr_en   = req_xfer && (req_if.command == afs_pkg::CMD_LOAD) &&
                        (32'(req_if.entry_index) < MAX_FRAMES);
   assign tbl_wr_addr = IDX_W'(req_if.entry_index);
   assign tbl_wr_data = TIME_BITS'(32'(req_if.entry_time));
   assign tbl_rd_en   = (state_ff == afs_pkg::ST_READ) && walk_more;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         afs_pkg::ST_IDLE: begin
            if (req_xfer) begin
               state_in = (req_if.command == afs_pkg::CMD_LOAD) ?
                          afs_pkg::ST_EMIT : afs_pkg::ST_CHECK;
            end
         end
         afs_pkg::ST_CHECK:   state_in = seq_done ? afs_pkg::ST_EMIT : afs_pkg::ST_READ;
         afs_pkg::ST_READ:    state_in = walk_more ? afs_pkg::ST_COMPARE : afs_pkg::ST_END;
         afs_pkg::ST_COMPARE: state_in = time_past ? afs_pkg::ST_READ : afs_pkg::ST_END;
         afs_pkg::ST_END:     state_in = afs_pkg::ST_EMIT;
         afs_pkg::ST_EMIT: begin
            if (rsp_free) begin
               state_in = afs_pkg::ST_IDLE;
            end
         end
         default: state_in = afs_pkg::ST_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      run_time_in    = run_time_ff;
      frame_index_in = frame_index_ff;
      reps_in        = reps_ff;
      res_active_in  = res_active_ff;
      res_one_in     = res_one_ff;
      res_two_in     = res_two_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_if.ready;
      unique case (state_ff)
         afs_pkg::ST_IDLE: begin
            if (req_xfer) begin
               res_active_in = 1'b0;
               res_one_in    = '0;
               res_two_in    = '0;
               if (req_if.command == afs_pkg::CMD_TICK) begin
                  run_time_in = time_sum[TIME_BITS] ? '1 : time_sum[TIME_BITS-1:0];
               end
            end
         end
         afs_pkg::ST_CHECK: begin
            res_active_in = 1'b0;
            res_one_in    = afs_pkg::FRAME_W'(frame_index_ff);
            res_two_in    = afs_pkg::FRAME_W'(frame_index_ff);
         end
         afs_pkg::ST_READ: begin
         end
         afs_pkg::ST_COMPARE: begin
            if (time_past) begin
               frame_index_in = next_frame[FI_W-1:0];
            end
         end
         afs_pkg::ST_END: begin
            if (!walk_more) begin
               if (repeat_enable_ff) begin
                  if (reps_ff != afs_pkg::REPS_MAX) begin
                     reps_in = reps_ff + afs_pkg::REPS_W'(1);
                  end
                  frame_index_in = '0;
                  run_time_in    = '0;
                  res_active_in  = 1'b1;
                  res_one_in     = '0;
                  res_two_in     = (count > FI_W'(1)) ? afs_pkg::FRAME_W'(1) : '0;
               end else begin
                  frame_index_in = count - FI_W'(1);
                  res_active_in  = 1'b0;
                  res_one_in     = afs_pkg::FRAME_W'(count - FI_W'(1));
                  res_two_in     = afs_pkg::FRAME_W'(count - FI_W'(1));
               end
            end else begin
               res_active_in = 1'b1;
               res_one_in    = afs_pkg::FRAME_W'(frame_index_ff);
               res_two_in    = (next_frame >= {1'b0, count}) ?
                               afs_pkg::FRAME_W'(frame_index_ff) :
                               afs_pkg::FRAME_W'(next_frame);
            end
         end
         afs_pkg::ST_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= afs_pkg::ST_IDLE;
         run_time_ff      <= '0;
         frame_index_ff   <= '0;
         reps_ff          <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         run_time_ff      <= run_time_in;
         frame_index_ff   <= frame_index_in;
         reps_ff          <= reps_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_active_ff <= res_active_in;
      res_one_ff    <= res_one_in;
      res_two_ff    <= res_two_in;
      if (state_ff == afs_pkg::ST_EMIT && rsp_free) begin
         rsp_active_ff <= res_active_ff;
         rsp_one_ff    <= res_one_ff;
         rsp_two_ff    <= res_two_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_count_ff   <= afs_pkg::FRAME_COUNT_RESET;
         repeat_enable_ff <= 1'b0;
         repeat_limit_ff  <= '0;
      end else if (csr_if.valid && csr_if.ready) begin
         unique case (csr_if.index)
            afs_pkg::REG_FRAME_COUNT:
               frame_count_ff <= csr_if.data[afs_pkg::COUNT_W-1:0];
            afs_pkg::REG_REPEAT_ENABLE:
               repeat_enable_ff <= csr_if.data[0];
            afs_pkg::REG_REPEAT_LIMIT:
               repeat_limit_ff <= csr_if.data[afs_pkg::LIMIT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   a_busy_after_xfer : assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> !req_if.ready)
      else $error("request taken while an item is in work");

   a_compare_after_read : assert property (@(posedge clock) disable iff (reset)
      (state_ff == afs_pkg::ST_COMPARE) |-> ($past(state_ff) == afs_pkg::ST_READ))
      else $error("compare without a table read");

   a_frame_pair : assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.active) |->
         ((rsp_if.frame_next == rsp_if.frame_cur) ||
          (rsp_if.frame_next == rsp_if.frame_cur + afs_pkg::FRAME_W'(1))))
      else $error("next frame is not current or current plus one");

   a_index_bound : assert property (@(posedge clock) disable iff (reset)
      (state_ff == afs_pkg::ST_COMPARE) |-> (frame_index_ff < count))
      else $error("walk read past the frame count");

endmodule

// ----- verif/animation_frame_sequencer_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// animation_frame_sequencer_tb - keyframe sequencer testbench
// Loads the end time table, then runs directed ticks and loads and random
// items under several register settings: stop at end, wrap with a
// repetition limit, repeat forever, saturated repetitions, out-of-range
// frame counts and limits. A scoreboard predicts every result from accepted
// items and checks the response stream field by field. Both channels idle at
// random; one long response hold-off backs up the request side.
// ----------------------------------------------------------------------------
module animation_frame_sequencer_tb;

   localparam int TABLE_DEPTH = afs_pkg::MAX_FRAMES_DEFAULT;
   localparam int IDLE_PCT    = 22;
   localparam int CALM_FROM   = 1100;
   localparam int CALM_TO     = 1400;
   localparam int HOLD_AT     = 400;
   localparam int HOLD_CYCLES = 300;
   localparam int TAIL_CYCLES = 2 * TABLE_DEPTH + 10;
   localparam int CYCLE_LIMIT = 2000000;
   localparam logic [afs_pkg::ENTRY_W-1:0] TIME_FULL = '1;

   typedef struct packed {
      logic [afs_pkg::COMMAND_W-1:0] command;
      logic [afs_pkg::DELTA_W-1:0]   time_delta;
      logic [afs_pkg::SLOT_W-1:0]    entry_index;
      logic [afs_pkg::ENTRY_W-1:0]   entry_time;
   } sequencer_item_type;

   typedef struct packed {
      logic                        active;
      logic [afs_pkg::FRAME_W-1:0] frame_cur;
      logic [afs_pkg::FRAME_W-1:0] frame_next;
   } frame_result_type;

   class frame_scoreboard_type;
      logic [afs_pkg::COUNT_W-1:0] frame_count;
      logic                        repeat_enable;
      logic [afs_pkg::LIMIT_W-1:0] repeat_limit;
      logic [afs_pkg::ENTRY_W-1:0] run_time;
      logic [afs_pkg::COUNT_W-1:0] frame_index;
      logic [afs_pkg::REPS_W-1:0]  reps_completed;
      logic [afs_pkg::ENTRY_W-1:0] end_times [TABLE_DEPTH];
      frame_result_type            expected_frames [$];
      int                          errors;
      int                          accepted;
      int                          checked;

      function new();
         frame_count    = afs_pkg::FRAME_COUNT_RESET;
         repeat_enable  = 1'b0;
         repeat_limit   = '0;
         run_time       = '0;
         frame_index    = '0;
         reps_completed = '0;
         errors         = 0;
         accepted       = 0;
         checked        = 0;
      endfunction

      function void write_register(logic [afs_pkg::CSR_IDX_W-1:0] idx,
                                   logic [afs_pkg::CSR_DATA_W-1:0] data);
         case (idx)
            afs_pkg::REG_FRAME_COUNT:   frame_count = data[afs_pkg::COUNT_W-1:0];
            afs_pkg::REG_REPEAT_ENABLE: repeat_enable = data[0];
            afs_pkg::REG_REPEAT_LIMIT:  repeat_limit = data[afs_pkg::LIMIT_W-1:0];
            default: ;
         endcase
      endfunction

      function frame_result_type advance_sequence(sequencer_item_type item);
         int                          count;
         int                          limit;
         logic [afs_pkg::DELTA_W:0]   sum;
         logic [afs_pkg::COUNT_W-1:0] nxt;
         count = int'(frame_count);
         if (count < 1) count = 1;
         if (count > TABLE_DEPTH) count = TABLE_DEPTH;
         limit = int'($signed(repeat_limit));
         if (item.command == afs_pkg::CMD_LOAD) begin
            end_times[item.entry_index] = item.entry_time;
            return '0;
         end
         sum = {1'b0, run_time} + {1'b0, item.time_delta};
         run_time = sum[afs_pkg::DELTA_W] ? TIME_FULL : sum[afs_pkg::DELTA_W-1:0];
         if (limit != -1 && int'(reps_completed) > limit) begin
            return '{1'b0, frame_index[afs_pkg::FRAME_W-1:0],
                     frame_index[afs_pkg::FRAME_W-1:0]};
         end
         while (int'(frame_index) < count &&
                run_time > end_times[frame_index[afs_pkg::SLOT_W-1:0]])
            frame_index++;
         if (int'(frame_index) >= count) begin
            if (repeat_enable) begin
               if (reps_completed != afs_pkg::REPS_MAX) reps_completed++;
               frame_index = '0;
               run_time = '0;
            end else begin
               frame_index = afs_pkg::COUNT_W'(count - 1);
               return '{1'b0, frame_index[afs_pkg::FRAME_W-1:0],
                        frame_index[afs_pkg::FRAME_W-1:0]};
            end
         end
         nxt = frame_index + afs_pkg::COUNT_W'(1);
         if (int'(nxt) >= count) nxt = frame_index;
         return '{1'b1, frame_index[afs_pkg::FRAME_W-1:0], nxt[afs_pkg::FRAME_W-1:0]};
      endfunction

      function void note_request(sequencer_item_type item);
         expected_frames.insert(expected_frames.size(), advance_sequence(item));
         accepted++;
      endfunction

      function void check_result(logic active, logic [afs_pkg::FRAME_W-1:0] f1,
                                 logic [afs_pkg::FRAME_W-1:0] f2);
         frame_result_type exp_res;
         checked++;
         if (expected_frames.size() == 0) begin
            $display("%0t: result expected none, got active=%0d frame_cur=%0d frame_next=%0d",
                     $time, active, f1, f2);
            errors++;
            return;
         end
         exp_res = expected_frames.pop_front();
         if (active !== exp_res.active) begin
            $display("%0t: active expected %0d, got %0d", $time, exp_res.active, active);
            errors++;
         end
         if (f1 !== exp_res.frame_cur) begin
            $display("%0t: frame_cur expected %0d, got %0d", $time, exp_res.frame_cur, f1);
            errors++;
         end
         if (f2 !== exp_res.frame_next) begin
            $display("%0t: frame_next expected %0d, got %0d", $time, exp_res.frame_next, f2);
            errors++;
         end
      endfunction

      function int pending();
         return expected_frames.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   int   cycle_count = 0;
   int   hold_left = 0;
   bit   held = 1'b0;

   frame_scoreboard_type sb = new();

   afs_req_if req_if ();
   afs_rsp_if rsp_if ();
   afs_csr_if csr_if ();

   animation_frame_sequencer DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // response side: check, then choose ready; one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            sb.check_result(rsp_if.active, rsp_if.frame_cur, rsp_if.frame_next);
         end
         if (!held && sb.checked >= HOLD_AT) begin
            held = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (sb.checked >= CALM_FROM && sb.checked < CALM_TO) begin
            rsp_if.ready <= 1'b1;
         end else begin
            rsp_if.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   function automatic sequencer_item_type make_tick(logic [afs_pkg::DELTA_W-1:0] delta);
      sequencer_item_type item;
      item.command     = afs_pkg::CMD_TICK;
      item.time_delta  = delta;
      item.entry_index = afs_pkg::SLOT_W'($urandom);
      item.entry_time  = afs_pkg::ENTRY_W'($urandom);
      return item;
   endfunction

   function automatic sequencer_item_type make_load(logic [afs_pkg::SLOT_W-1:0] slot,
                                                    logic [afs_pkg::ENTRY_W-1:0] end_time);
      sequencer_item_type item;
      item.command     = afs_pkg::CMD_LOAD;
      item.time_delta  = afs_pkg::DELTA_W'($urandom);
      item.entry_index = slot;
      item.entry_time  = end_time;
      return item;
   endfunction

   function automatic sequencer_item_type random_item(int scale);
      int                          pick;
      int                          slot;
      logic [afs_pkg::DELTA_W-1:0] delta;
      sequencer_item_type          item;
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
         pick = $urandom_range(0, 99);
         if (pick < 80)      delta = afs_pkg::DELTA_W'($urandom_range(0, 3 * scale));
         else if (pick < 88) delta = '0;
         else if (pick < 95) delta = afs_pkg::DELTA_W'($urandom);
         else                delta = TIME_FULL;
         return make_tick(delta);
      end else if (pick < 95) begin
         slot = $urandom_range(0, TABLE_DEPTH - 1);
         return make_load(afs_pkg::SLOT_W'(slot),
                          afs_pkg::ENTRY_W'(slot * scale + $urandom_range(0, scale - 1)));
      end
      item = $bits(sequencer_item_type)'({$urandom, $urandom});
      item.time_delta = afs_pkg::DELTA_W'($urandom);
      return item;
   endfunction

   task automatic push_request(sequencer_item_type item);
      bit calm;
      calm = sb.accepted >= CALM_FROM && sb.accepted < CALM_TO;
      if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.command     <= item.command;
      req_if.time_delta  <= item.time_delta;
      req_if.entry_index <= item.entry_index;
      req_if.entry_time  <= item.entry_time;
      do @(posedge clock); while (!req_if.ready);
      sb.note_request(item);
   endtask

   task automatic drain_results();
      req_if.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_reg(logic [afs_pkg::CSR_IDX_W-1:0] idx,
                            logic [afs_pkg::CSR_DATA_W-1:0] data);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= data;
      do @(posedge clock); while (!csr_if.ready);
      sb.write_register(idx, data);
   endtask

   task automatic program_sequence(logic [afs_pkg::COUNT_W-1:0] count, logic en,
                                   logic [afs_pkg::LIMIT_W-1:0] lim);
      drain_results();
      repeat (4) @(posedge clock);
      write_reg(afs_pkg::REG_FRAME_COUNT, afs_pkg::CSR_DATA_W'(count));
      write_reg(afs_pkg::REG_REPEAT_ENABLE, afs_pkg::CSR_DATA_W'(en));
      write_reg(afs_pkg::REG_REPEAT_LIMIT, lim);
      csr_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic fill_table(int scale);
      logic [afs_pkg::ENTRY_W-1:0] end_time;
      end_time = '0;
      for (int s = 0; s < TABLE_DEPTH; s++) begin
         end_time += afs_pkg::ENTRY_W'($urandom_range(1, scale));
         push_request(make_load(afs_pkg::SLOT_W'(s), end_time));
      end
   endtask

   task automatic run_phase(logic [afs_pkg::COUNT_W-1:0] count, logic en,
                            logic [afs_pkg::LIMIT_W-1:0] lim,
                            int scale, int item_total, bit refill);
      program_sequence(count, en, lim);
      if (refill) fill_table(scale);
      for (int k = 0; k < item_total; k++) begin
         if (k == item_total / 2) drain_results();
         push_request(random_item(scale));
      end
   endtask

   initial begin
      reset              = 1'b1;
      req_if.valid       = 1'b0;
      req_if.command     = afs_pkg::CMD_TICK;
      req_if.time_delta  = '0;
      req_if.entry_index = '0;
      req_if.entry_time  = '0;
      csr_if.valid       = 1'b0;
      csr_if.index       = afs_pkg::REG_FRAME_COUNT;
      csr_if.data        = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: one frame, stop at end
      fill_table(1000);
      push_request(make_tick('0));
      push_request(make_tick(TIME_FULL));
      push_request(make_tick(TIME_FULL));
      push_request(make_load(afs_pkg::SLOT_W'(TABLE_DEPTH - 1), TIME_FULL));
      push_request(make_load('0, '0));
      push_request(make_tick(afs_pkg::DELTA_W'(1)));

      // saturated time parks on an all-ones end time, then wraps once it drops
      program_sequence(afs_pkg::COUNT_W'(TABLE_DEPTH), 1'b1, 9'd254);
      push_request(make_tick('0));
      push_request(make_tick(afs_pkg::DELTA_W'(1)));
      push_request(make_load(afs_pkg::SLOT_W'(TABLE_DEPTH - 1), afs_pkg::ENTRY_W'(1000)));
      push_request(make_tick('0));
      push_request(make_tick(afs_pkg::DELTA_W'(1)));
      push_request(make_tick(afs_pkg::DELTA_W'(5000)));
      push_request(make_tick(TIME_FULL));

      run_phase(afs_pkg::COUNT_W'(TABLE_DEPTH), 1'b0, 9'd0, 1000, 180, 1'b1);
      run_phase(7'd8, 1'b1, 9'd3, 500, 150, 1'b0);
      run_phase(7'd5, 1'b1, 9'd254, 300, 180, 1'b0);
      run_phase(7'd0, 1'b1, afs_pkg::LIMIT_FOREVER, 200, 480, 1'b1);
      run_phase(7'd127, 1'b0, 9'h100, 1000, 50, 1'b0);
      run_phase(afs_pkg::COUNT_W'(TABLE_DEPTH), 1'b1, afs_pkg::LIMIT_FOREVER, 400, 300, 1'b1);
      run_phase(7'd33, 1'b1, 9'd254, 1000, 50, 1'b0);
      run_phase(7'd100, 1'b0, 9'h1FE, 800, 40, 1'b0);
      run_phase(afs_pkg::COUNT_W'($urandom_range(1, TABLE_DEPTH)), 1'($urandom_range(0, 1)),
                afs_pkg::LIMIT_FOREVER, 700, 200, 1'b1);

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
